/* src/kss_pkg.sv */
// kss_pkg: shared widths and stream field offsets for the keyframe scalar sampler
// no dependencies; imported by keyframe_scalar_sampler_unit
`default_nettype none

package kss_pkg;

   // item field widths
   localparam int SLOT_W  = 6;
   localparam int TIME_W  = 32;
   localparam int VALUE_W = 32;
   localparam int KEYS_W  = 7;

   // req_tdata layout, lowest bit first: key_slot, key_time, key_value, query_time
   localparam int SLOT_LSB   = 0;
   localparam int KTIME_LSB  = SLOT_LSB + SLOT_W;
   localparam int KVALUE_LSB = KTIME_LSB + TIME_W;
   localparam int QTIME_LSB  = KVALUE_LSB + VALUE_W;
   localparam int REQ_BITS   = QTIME_LSB + TIME_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = VALUE_W;

   // function codes carried on req_tuser
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // divider: the quotient never exceeds the 33-bit weight difference magnitude
   localparam int MAG_W  = VALUE_W + 1;
   localparam int PROD_W = MAG_W + TIME_W;

endpackage : kss_pkg

`default_nettype wire

/* src/keyframe_scalar_sampler_unit.sv */
// keyframe_scalar_sampler_unit: a load item is written to the key memory as it is accepted, no result.
// a sample item clamps to an end key, or searches the keys in use and interpolates, skipping
// the multiply and divide on a flat pair; its length is set by the single read port of the key
// memory (a read state and a compare state per search step) and the 1 bit/cycle
// divider (33 steps).
// one item in flight at a time; the result register lets the next item in while it waits.
// reset (synchronous) returns to idle, empties the result register, sets keys_in_use to 1.
`default_nettype none

module keyframe_scalar_sampler_unit #(
   parameter int MAX_KEYS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [kss_pkg::REQ_DATA_W-1:0] req_tdata,  // key_slot, key_time, key_value, query_time
   input  wire logic                            req_tuser,  // func
   // result stream
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [kss_pkg::RSP_DATA_W-1:0] rsp_tdata,  // sampled_value
   // configuration
   input  wire logic                            csr_wen,
   input  wire logic [kss_pkg::KEYS_W-1:0]     csr_wdata   // keys_in_use
);
   import kss_pkg::*;

   localparam int AW = $clog2(MAX_KEYS);
   localparam int NW = $clog2(MAX_KEYS + 1);
   localparam logic [NW-1:0] MaxN = NW'(MAX_KEYS);
   localparam logic [NW-1:0] OneN = NW'(1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FIRST = 4'd1;
   localparam logic [3:0] S_LAST  = 4'd2;
   localparam logic [3:0] S_LCHK  = 4'd3;
   localparam logic [3:0] S_SRCH  = 4'd4;
   localparam logic [3:0] S_CMP   = 4'd5;
   localparam logic [3:0] S_RDA   = 4'd6;
   localparam logic [3:0] S_RDB   = 4'd7;
   localparam logic [3:0] S_GETB  = 4'd8;
   localparam logic [3:0] S_PREP  = 4'd9;
   localparam logic [3:0] S_MUL   = 4'd10;
   localparam logic [3:0] S_DIV   = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   // key memory: {value, time} per slot
   logic [VALUE_W+TIME_W-1:0] key_mem [MAX_KEYS];
   logic [VALUE_W+TIME_W-1:0] rd_data_ff;
   logic [AW-1:0]             rd_addr;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;

   logic [3:0]          state_ff, state_in;
   logic [KEYS_W-1:0]   keys_ff;
   logic [TIME_W-1:0]   query_ff, query_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [NW-1:0]       lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, u_ff, u_in;
   logic [TIME_W-1:0]   t0_ff, t0_in, t1_ff, t1_in;
   logic [VALUE_W-1:0]  v0_ff, v0_in, v1_ff, v1_in;
   logic [TIME_W-1:0]   span_ff, span_in, dt_ff, dt_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [MAG_W-1:0]    low_ff, low_in, quot_ff, quot_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [VALUE_W-1:0]  res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic [NW-1:0]       n_calc;
   logic [NW:0]         mid_sum;
   logic [NW-1:0]       n_m1;
   logic [TIME_W-1:0]   rd_time;
   logic [VALUE_W-1:0]  rd_value;
   logic [SLOT_W-1:0]   req_slot;
   logic [PROD_W-1:0]   prod;
   logic [MAG_W-1:0]    trial;
   logic                trial_ge;
   logic [MAG_W:0]      diff;
   logic [TIME_W-1:0]   dt_raw;
   logic [VALUE_W+2:0]  sum;
   logic [VALUE_W+2:0]  part;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_slot = req_tdata[KTIME_LSB-1:SLOT_LSB];
   assign rd_time  = rd_data_ff[TIME_W-1:0];
   assign rd_value = rd_data_ff[VALUE_W+TIME_W-1:TIME_W];
   assign n_m1     = n_ff - OneN;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};

   // loads only happen in idle and read data is only used outside it, so no same-cycle overlap
   assign wr_en   = req_fire && (req_tuser == FUNC_LOAD)
                    && ({26'd0, req_slot} < 32'(MAX_KEYS));
   assign wr_addr = AW'(req_slot);

   always_comb begin
      if (keys_ff == '0) begin
         n_calc = OneN;
      end else if ({25'd0, keys_ff} > 32'(MAX_KEYS)) begin
         n_calc = MaxN;
      end else begin
         n_calc = NW'(keys_ff);
      end
   end

   always_comb begin
      case (state_ff)
         S_FIRST: rd_addr = '0;
         S_LAST:  rd_addr = n_m1[AW-1:0];
         S_SRCH:  rd_addr = mid_sum[AW:1];
         S_RDA:   rd_addr = AW'(u_ff - OneN);
         S_RDB:   rd_addr = u_ff[AW-1:0];
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= {req_tdata[QTIME_LSB-1:KVALUE_LSB],
                              req_tdata[KVALUE_LSB-1:KTIME_LSB]};
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   // arithmetic helpers
   assign prod     = PROD_W'(mag_ff) * PROD_W'(dt_ff);
   assign trial    = {rem_ff, low_ff[MAG_W-1]};
   assign trial_ge = (trial >= {1'b0, span_ff});
   assign diff     = {{2{v1_ff[VALUE_W-1]}}, v1_ff} - {{2{v0_ff[VALUE_W-1]}}, v0_ff};
   assign dt_raw   = (query_ff >= t0_ff) ? (query_ff - t0_ff) : '0;
   assign part     = neg_ff ? -{2'b00, quot_ff} : {2'b00, quot_ff};
   assign sum      = {{3{v0_ff[VALUE_W-1]}}, v0_ff} + part;

   always_comb begin
      state_in     = state_ff;
      query_in     = query_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      u_in         = u_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      span_in      = span_ff;
      dt_in        = dt_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_tuser == FUNC_SAMPLE)) begin
               query_in = req_tdata[QTIME_LSB+TIME_W-1:QTIME_LSB];
               n_in     = n_calc;
               state_in = S_FIRST;
            end
         end
         S_FIRST: state_in = S_LAST;
         S_LAST: begin
            if (query_ff <= rd_time) begin
               res_in   = rd_value;
               state_in = S_OUT;
            end else begin
               state_in = S_LCHK;
            end
         end
         S_LCHK: begin
            if (query_ff >= rd_time) begin
               res_in   = rd_value;
               state_in = S_OUT;
            end else begin
               lo_in    = '0;
               hi_in    = n_ff;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[NW:1];
               state_in = S_CMP;
            end else begin
               if (lo_ff < OneN) begin
                  u_in = OneN;
               end else if (lo_ff > n_m1) begin
                  u_in = n_m1;
               end else begin
                  u_in = lo_ff;
               end
               state_in = S_RDA;
            end
         end
         S_CMP: begin
            if (query_ff < rd_time) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + OneN;
            end
            state_in = S_SRCH;
         end
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            t0_in    = rd_time;
            v0_in    = rd_value;
            state_in = S_GETB;
         end
         S_GETB: begin
            t1_in    = rd_time;
            v1_in    = rd_value;
            state_in = S_PREP;
         end
         S_PREP: begin
            if (t1_ff <= t0_ff) begin
               // flat or descending pair: hold the earlier weight
               res_in   = v0_ff;
               state_in = S_OUT;
            end else begin
               span_in  = t1_ff - t0_ff;
               dt_in    = (dt_raw > (t1_ff - t0_ff)) ? (t1_ff - t0_ff) : dt_raw;
               neg_in   = diff[MAG_W];
               mag_in   = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // quotient fits 33 bits, so the upper part starts below span
            rem_in   = prod[PROD_W-1:MAG_W];
            low_in   = prod[MAG_W-1:0];
            quot_in  = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = trial_ge ? TIME_W'(trial - {1'b0, span_ff}) : trial[TIME_W-1:0];
            low_in  = {low_ff[MAG_W-2:0], 1'b0};
            quot_in = {quot_ff[MAG_W-2:0], trial_ge};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MAG_W - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!sum[VALUE_W+2] && (sum[VALUE_W+1:VALUE_W-1] != 3'b000)) begin
               res_in = {1'b0, {(VALUE_W-1){1'b1}}};
            end else if (sum[VALUE_W+2] && (sum[VALUE_W+1:VALUE_W-1] != 3'b111)) begin
               res_in = {1'b1, {(VALUE_W-1){1'b0}}};
            end else begin
               res_in = sum[VALUE_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         keys_ff      <= KEYS_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            keys_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      n_ff        <= n_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      u_ff        <= u_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      span_ff     <= span_in;
      dt_ff       <= dt_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule : keyframe_scalar_sampler_unit

`default_nettype wire
